// ===== sv/oidc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oidc_pkg
// Types, register codes and arithmetic helpers for the orbit damper block.
// ----------------------------------------------------------------------------
package oidc_pkg;

  // Fraction bits of the pose and offset words.
  localparam int FRACTION_BITS = 16;
  // The pointer gain is Q0.24; bring dx*gain down to the pose scale.
  localparam int MOVE_SHIFT    = 24 - FRACTION_BITS;
  localparam int MOVE_W        = 41;   // 16-bit signed times 24-bit unsigned

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_INERTIA   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_LIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_LIM = 3'd6;

  localparam logic [15:0] INERTIA_RST = 16'd58982;
  localparam logic [15:0] STOP_RST    = 16'd66;
  localparam logic [23:0] GAIN_RST    = 24'd16777;
  // Beta limits: lower 0.01, upper pi, both Q16.16.
  localparam logic [63:0] BETA_LIM_RST = 64'h0003_243F_0000_028F;

  // Limit enable bit positions.
  localparam int EN_ALPHA_LO  = 0;
  localparam int EN_ALPHA_HI  = 1;
  localparam int EN_BETA_LO   = 2;
  localparam int EN_BETA_HI   = 3;
  localparam int EN_RADIUS_LO = 4;
  localparam int EN_RADIUS_HI = 5;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_POSE  = 2'd2,
    KIND_NUDGE = 2'd3
  } kind_e;

  typedef struct packed {
    logic [15:0] inertia;
    logic [15:0] stop;
    logic [23:0] gain;
    logic [5:0]  enables;
    logic [63:0] alpha_lim;
    logic [63:0] beta_lim;
    logic [63:0] radius_lim;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] move_dx;
    logic signed [15:0] move_dy;
    logic signed [31:0] pose_alpha;
    logic signed [31:0] pose_beta;
    logic signed [31:0] pose_radius;
    logic signed [31:0] nudge_amount;
  } item_t;

  typedef struct packed {
    logic signed [31:0] alpha;
    logic signed [31:0] beta;
    logic signed [31:0] radius;
    logic signed [31:0] vel_alpha;
    logic signed [31:0] vel_beta;
    logic signed [31:0] vel_radius;
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Scale by inertia, truncate toward zero, snap small offsets to zero.
  function automatic logic signed [31:0] decay(input logic signed [31:0] v,
                                               input logic [15:0] k,
                                               input logic [15:0] thr);
    logic signed [48:0] p;
    logic signed [48:0] r;
    logic [48:0]        mag;
    p = v * $signed({1'b0, k});
    if (p < 0) begin
      r = -((-p) >>> 16);
    end else begin
      r = p >>> 16;
    end
    mag = (r < 0) ? $unsigned(-r) : $unsigned(r);
    if (mag < {33'd0, thr}) begin
      r = '0;
    end
    return r[31:0];
  endfunction

  // Floor of dx*gain shifted down to the pose scale.
  function automatic logic signed [MOVE_W-1:0] scale_move(input logic signed [15:0] d,
                                                          input logic [23:0] g);
    logic signed [MOVE_W-1:0] prod;
    prod = d * $signed({1'b0, g});
    return prod >>> MOVE_SHIFT;
  endfunction

  // Lower limit first, then upper.
  function automatic logic signed [31:0] clamp(input logic signed [31:0] v,
                                               input logic [63:0] lim,
                                               input logic en_lo,
                                               input logic en_hi);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] r;
    lo = $signed(lim[31:0]);
    hi = $signed(lim[63:32]);
    r  = v;
    if (en_lo && (r < lo)) begin
      r = lo;
    end
    if (en_hi && (r > hi)) begin
      r = hi;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/oidc_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oidc_cfg
// Configuration register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module oidc_cfg import oidc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_INERTIA:    cfg_d.inertia    = cfg_data_i[15:0];
        REG_STOP:       cfg_d.stop       = cfg_data_i[15:0];
        REG_GAIN:       cfg_d.gain       = cfg_data_i[23:0];
        REG_ENABLES:    cfg_d.enables    = cfg_data_i[5:0];
        REG_ALPHA_LIM:  cfg_d.alpha_lim  = cfg_data_i;
        REG_BETA_LIM:   cfg_d.beta_lim   = cfg_data_i;
        REG_RADIUS_LIM: cfg_d.radius_lim = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inertia    <= INERTIA_RST;
      cfg_q.stop       <= STOP_RST;
      cfg_q.gain       <= GAIN_RST;
      cfg_q.enables    <= '0;
      cfg_q.alpha_lim  <= '0;
      cfg_q.beta_lim   <= BETA_LIM_RST;
      cfg_q.radius_lim <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/oidc_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oidc_update
// Next pose and offsets for one item, from the current state.
// ----------------------------------------------------------------------------
module oidc_update import oidc_pkg::*; (
  input  wire cfg_t   cfg_i,
  input  wire item_t  item_i,
  input  wire state_t state_i,
  output state_t      state_o,
  output logic        in_motion_o
);

  logic                     moving;
  logic signed [31:0]       a_step;
  logic signed [31:0]       b_step;
  logic signed [31:0]       r_step;
  logic signed [MOVE_W-1:0] ax;
  logic signed [MOVE_W-1:0] ay;

  assign moving = (state_i.vel_alpha != '0) || (state_i.vel_beta != '0)
               || (state_i.vel_radius != '0);

  assign ax = scale_move(item_i.move_dx, cfg_i.gain);
  assign ay = scale_move(item_i.move_dy, cfg_i.gain);

  // Advance alpha and beta by their offsets and radius against its offset, only while something is moving.
  assign a_step = moving ? sat32(64'(state_i.alpha) + 64'(state_i.vel_alpha))
                         : state_i.alpha;
  assign b_step = moving ? sat32(64'(state_i.beta) + 64'(state_i.vel_beta))
                         : state_i.beta;
  assign r_step = moving ? sat32(64'(state_i.radius) - 64'(state_i.vel_radius))
                         : state_i.radius;

  always_comb begin
    state_o = state_i;
    unique case (item_i.kind)
      KIND_TICK: begin
        state_o.alpha  = clamp(a_step, cfg_i.alpha_lim,
                               cfg_i.enables[EN_ALPHA_LO], cfg_i.enables[EN_ALPHA_HI]);
        state_o.beta   = clamp(b_step, cfg_i.beta_lim,
                               cfg_i.enables[EN_BETA_LO], cfg_i.enables[EN_BETA_HI]);
        state_o.radius = clamp(r_step, cfg_i.radius_lim,
                               cfg_i.enables[EN_RADIUS_LO], cfg_i.enables[EN_RADIUS_HI]);
        if (moving) begin
          state_o.vel_alpha  = decay(state_i.vel_alpha, cfg_i.inertia, cfg_i.stop);
          state_o.vel_beta   = decay(state_i.vel_beta, cfg_i.inertia, cfg_i.stop);
          state_o.vel_radius = decay(state_i.vel_radius, cfg_i.inertia, cfg_i.stop);
        end
      end
      KIND_MOVE: begin
        state_o.vel_alpha = sat32(64'(state_i.vel_alpha) - 64'(ax));
        state_o.vel_beta  = sat32(64'(state_i.vel_beta) - 64'(ay));
      end
      KIND_POSE: begin
        state_o.alpha  = item_i.pose_alpha;
        state_o.beta   = item_i.pose_beta;
        state_o.radius = item_i.pose_radius;
      end
      KIND_NUDGE: begin
        state_o.vel_radius = sat32(64'(state_i.vel_radius) + 64'(item_i.nudge_amount));
      end
      default: ;
    endcase
  end

  assign in_motion_o = (state_o.vel_alpha != '0) || (state_o.vel_beta != '0)
                    || (state_o.vel_radius != '0);

endmodule
`default_nettype wire

// ===== sv/orbit_inertia_damper_clamp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orbit_inertia_damper_clamp
// Orbit pose with damped velocity offsets and per-axis limit clamping.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         s_axis_tvalid/tready   tuser kind, tdata item fields
//  m_axis    out        m_axis_tvalid/tready   tdata pose and in_motion
//  cfg       in         cfg_valid_i/ready_o    cfg_index_i, cfg_data_i
//
//  One item per cycle sustained while the output is not stalled; each item
//  passes the input register, then update logic into state and result.
//  The pose and offset registers change in the same edge that loads the
//  result, so consecutive items chain without bubbles.
//  A stalled output holds the result and the input register; ready drops
//  only when both are full. Reset restores the register defaults and
//  zeroes pose and offsets; cfg is always ready.
// ----------------------------------------------------------------------------
module orbit_inertia_damper_clamp import oidc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [15:0] move_dx, [31:16] move_dy, [63:32] pose_alpha, [95:64] pose_beta,
  // [127:96] pose_radius, [159:128] nudge_amount
  input  wire logic [159:0]          s_axis_tdata,
  // [1:0] kind
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [31:0] alpha_now, [63:32] beta_now, [95:64] radius_now, [96] in_motion,
  // [103:97] zero
  output logic [103:0]               m_axis_tdata,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t   cfg;
  item_t  in_q;
  logic   in_valid_q;
  state_t state_q;
  state_t state_d;
  logic   in_motion_d;
  logic   out_valid_q;
  logic [96:0] out_q;
  logic   adv;

  oidc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  oidc_update u_update (
    .cfg_i       (cfg),
    .item_i      (in_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .in_motion_o (in_motion_d)
  );

  // Advance when an item waits and the result slot is free or being taken.
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.kind         <= kind_e'(s_axis_tuser);
      in_q.move_dx      <= s_axis_tdata[15:0];
      in_q.move_dy      <= s_axis_tdata[31:16];
      in_q.pose_alpha   <= s_axis_tdata[63:32];
      in_q.pose_beta    <= s_axis_tdata[95:64];
      in_q.pose_radius  <= s_axis_tdata[127:96];
      in_q.nudge_amount <= s_axis_tdata[159:128];
    end
    if (adv) begin
      out_q <= {in_motion_d, state_d.radius, state_d.beta, state_d.alpha};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q};

`ifndef SYNTHESIS
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  a_adv_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid)
    else $error("advanced item produced no result");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(state_q))
    else $error("state changed without an item");

  a_motion_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (m_axis_tdata[96] == ((state_q.vel_alpha != '0) || (state_q.vel_beta != '0)
                                  || (state_q.vel_radius != '0))))
    else $error("in_motion disagrees with offsets");

  a_pose_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (in_q.kind == KIND_POSE)) |=>
      (m_axis_tdata[31:0] == $past(in_q.pose_alpha)))
    else $error("pose load not reflected in result");
`endif

endmodule
`default_nettype wire
